FILE: rtl/core/stb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Shared constants, codes and result packing for the timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int DUR_W     = 32;
    localparam int TYPE_W    = 4;
    localparam int OWNER_W   = 16;
    localparam int SLOT_W    = 5;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int TICK_W    = 32;
    localparam int CUR_W     = 2;
    localparam int MPT_W     = 10;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 96;
    localparam int DIV_CNT_W = 6;
    localparam int HK_W      = 7;

    localparam logic [HK_W-1:0]    HK_LAST    = 7'd99;
    localparam logic [5:0]         BLINK_MASK = 6'd0;
    localparam logic [TYPE_W-1:0]  TYPE_MIN   = 4'd1;
    localparam logic [TYPE_W-1:0]  TYPE_MAX   = 4'd10;
    localparam logic [TYPE_W-1:0]  TYPE_PERIODIC = 4'd2;

    localparam logic [KIND_W-1:0] KIND_EXPIRY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    localparam logic [CUR_W-1:0] CUR_NONE  = 2'd0;
    localparam logic [CUR_W-1:0] CUR_ERASE = 2'd1;
    localparam logic [CUR_W-1:0] CUR_DRAW  = 2'd2;

    localparam logic CFG_MS_PER_TICK = 1'b0;
    localparam logic CFG_BLINK_EN    = 1'b1;

    typedef logic [OUT_DATA_W-1:0] t_out_data;

    function automatic t_out_data pack_result(
        input logic [SLOT_W-1:0]   slot,
        input logic [OWNER_W-1:0]  owner,
        input logic [STATUS_W-1:0] status,
        input logic [TICK_W-1:0]   ticks,
        input logic [TICK_W-1:0]   tms,
        input logic                hk,
        input logic [CUR_W-1:0]    cur
    );
        t_out_data d;
        d = '0;
        d[4:0]   = slot;
        d[20:5]  = owner;
        d[22:21] = status;
        d[54:23] = ticks;
        d[86:55] = tms;
        d[87]    = hk;
        d[89:88] = cur;
        return d;
    endfunction

endpackage

FILE: rtl/core/stb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_div
// Restoring divider, one quotient bit per cycle, for the reload count.
// ----------------------------------------------------------------------------
module stb_div
    import stb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DUR_W-1:0]   i_dividend,
    input  logic [MPT_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DUR_W-1:0]   o_quotient
);

    logic [MPT_W:0]     r_rem;
    logic [DUR_W-1:0]   r_quo;
    logic [MPT_W-1:0]   r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic               r_done;
    logic [MPT_W:0]     trial;
    logic               fits;

    always_comb begin
        trial = {r_rem[MPT_W-1:0], r_quo[DUR_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DUR_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[DUR_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/stb_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_mem
// Timer entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stb_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int WIDTH = 81
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/software_timer_bank_tick_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank_tick_top
// Bank of countdown timers: ticks sweep the entry store, creates allocate.
//
// Channel  Dir  Signals                                  Carries
// s        in   i_s_tvalid o_s_tready i_s_tdata i_s_tuser tick or create command
// m        out  o_m_tvalid i_m_tready o_m_tdata o_m_tuser expiry, summary, create
//                o_m_tlast
// cfg      in   i_cfg_wr_en i_cfg_addr i_cfg_wdata         ms_per_tick, blink enable
//
// A tick sweeps the F allocated slots, one store read per slot pipelined
// with the write-back; a create waits on the 32-step bit-serial divider,
// and a rejected create skips the divider. Output stalls hold either.
// Slots are allocated in order and never freed, so a fill count stands in for
// the in-use flags; reset needs no clearing pass. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module software_timer_bank_tick_top
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // duration_ms, timer_type, owner_handle
    input  logic                  i_s_tuser,   // cmd
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // slot, owner, status, ticks_total,
                                               // time_ms, housekeeping_due, cursor_action
    output logic [KIND_W-1:0]     o_m_tuser,   // kind
    output logic                  o_m_tlast,   // last
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_addr,
    input  logic [MPT_W-1:0]      i_cfg_wdata
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int EW = 1 + 2 * COUNT_BITS + OWNER_W;
    localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam logic [63:0] CNT_MAX = (COUNT_BITS == 64) ? '1 :
                                      ((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SWEEP   = 3'd1;
    localparam logic [2:0] S_SUMMARY = 3'd2;
    localparam logic [2:0] S_DIV     = 3'd3;
    localparam logic [2:0] S_RESULT  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [MPT_W-1:0]     r_mpt;
    logic                 r_blink;
    logic [TICK_W-1:0]    r_ticks;
    logic [TICK_W-1:0]    r_clock;
    logic [HK_W-1:0]      r_hk_cnt;
    logic                 r_phase;
    logic                 r_hk;
    logic [CUR_W-1:0]     r_cur;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_rq_cnt;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_rd_vld;
    logic                 r_periodic;
    logic [OWNER_W-1:0]   r_owner;
    logic [STATUS_W-1:0]  r_status;
    logic [IW-1:0]        r_res_idx;
    logic                 r_o_vld;
    t_out_data            r_o_data;
    logic [KIND_W-1:0]    r_o_kind;
    logic                 r_o_last;

    logic                 s_acc;
    logic                 out_free;
    logic [MPT_W-1:0]     tick_len;
    logic [DUR_W-1:0]     in_dur;
    logic [TYPE_W-1:0]    in_type;
    logic [OWNER_W-1:0]   in_owner;
    logic [DUR_W-1:0]     dur_adj;
    logic                 type_ok;
    logic [TICK_W-1:0]    tick_nxt;
    logic [HK_W-1:0]      hk_nxt;
    logic                 blink_hit;

    logic                 div_start;
    logic                 div_done;
    logic [DUR_W-1:0]     div_q;
    logic [63:0]          q_ext;
    logic [63:0]          q_sat;
    logic [COUNT_BITS-1:0] q_cnt;

    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [EW-1:0]        mem_wdata;
    logic                 mem_re;
    logic [EW-1:0]        mem_rdata;
    logic                 rd_per;
    logic [COUNT_BITS-1:0] rd_rel;
    logic [COUNT_BITS-1:0] rd_rem;
    logic [OWNER_W-1:0]   rd_own;
    logic                 rd_armed;
    logic                 rd_expire;
    logic [COUNT_BITS-1:0] rem_nxt;
    logic                 sweep_adv;
    logic                 rq_more;
    logic [XW-1:0]        exp_slot_x;
    logic [XW-1:0]        res_slot_x;

    assign in_dur   = i_s_tdata[31:0];
    assign in_type  = i_s_tdata[35:32];
    assign in_owner = i_s_tdata[51:36];

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_o_vld || i_m_tready;

    always_comb begin
        tick_len  = (r_mpt == '0) ? MPT_W'(1) : r_mpt;
        dur_adj   = (in_dur < DUR_W'(tick_len)) ? DUR_W'(tick_len) : in_dur;
        type_ok   = (in_type >= TYPE_MIN) && (in_type <= TYPE_MAX);
        tick_nxt  = r_ticks + 1'b1;
        hk_nxt    = ((tick_nxt == '0) || (r_hk_cnt == HK_LAST)) ? '0 : r_hk_cnt + 1'b1;
        blink_hit = (tick_nxt[5:0] == BLINK_MASK) && r_blink;
        div_start = s_acc && i_s_tuser && type_ok && (r_fill != CW'(NUM_TIMERS));
        q_ext     = {32'd0, div_q};
        q_sat     = (q_ext > CNT_MAX) ? CNT_MAX : q_ext;
        q_cnt     = q_sat[COUNT_BITS-1:0];
    end

    // sweep entry decode
    always_comb begin
        rd_per    = mem_rdata[EW-1];
        rd_rel    = mem_rdata[EW-2 -: COUNT_BITS];
        rd_rem    = mem_rdata[OWNER_W+COUNT_BITS-1 -: COUNT_BITS];
        rd_own    = mem_rdata[OWNER_W-1:0];
        rd_armed  = r_rd_vld && (rd_rem != '0);
        rd_expire = rd_armed && (rd_rem == COUNT_BITS'(1));
        rem_nxt   = rd_expire ? (rd_per ? rd_rel : '0) : rd_rem - 1'b1;
        sweep_adv = (r_state == S_SWEEP) && (!rd_expire || out_free);
        rq_more   = (r_rq_cnt < r_fill);
        mem_re    = sweep_adv && rq_more;
        exp_slot_x = XW'(r_rd_idx);
        res_slot_x = XW'(r_res_idx);
    end

    always_comb begin
        if (r_state == S_DIV) begin
            mem_we    = div_done;
            mem_waddr = r_fill[IW-1:0];
            mem_wdata = {r_periodic, q_cnt, q_cnt, r_owner};
        end else begin
            mem_we    = sweep_adv && rd_armed;
            mem_waddr = r_rd_idx;
            mem_wdata = {rd_per, rd_rel, rem_nxt, rd_own};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = !i_s_tuser ? S_SWEEP : (div_start ? S_DIV : S_RESULT);
                end
            end
            S_SWEEP: begin
                if (sweep_adv && !r_rd_vld && !rq_more) begin
                    n_state = S_SUMMARY;
                end
            end
            S_SUMMARY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mpt    <= MPT_W'(10);
            r_blink  <= 1'b0;
            r_ticks  <= '0;
            r_clock  <= '0;
            r_hk_cnt <= '0;
            r_phase  <= 1'b0;
            r_fill   <= '0;
            r_rq_cnt <= '0;
            r_rd_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == CFG_MS_PER_TICK) begin
                    r_mpt <= i_cfg_wdata;
                end else if (i_cfg_addr == CFG_BLINK_EN) begin
                    r_blink <= i_cfg_wdata[0];
                end
            end
            if (s_acc && !i_s_tuser) begin
                r_ticks  <= tick_nxt;
                r_clock  <= r_clock + TICK_W'(tick_len);
                r_hk_cnt <= hk_nxt;
                if (blink_hit) begin
                    r_phase <= !r_phase;
                end
                r_rq_cnt <= '0;
                r_rd_vld <= 1'b0;
            end
            if (sweep_adv) begin
                r_rd_vld <= rq_more;
                if (rq_more) begin
                    r_rq_cnt <= r_rq_cnt + 1'b1;
                end
            end
            if (r_state == S_DIV && div_done) begin
                r_fill <= r_fill + 1'b1;
            end
            if ((sweep_adv && rd_expire) ||
                ((r_state == S_SUMMARY || r_state == S_RESULT) && out_free)) begin
                r_o_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_hk  <= (hk_nxt == '0);
            r_cur <= blink_hit ? (r_phase ? CUR_DRAW : CUR_ERASE) : CUR_NONE;
            r_periodic <= (in_type == TYPE_PERIODIC);
            r_owner    <= in_owner;
            r_res_idx  <= '0;
            r_status   <= !type_ok ? ST_BAD_TYPE :
                          ((r_fill == CW'(NUM_TIMERS)) ? ST_FULL : ST_OK);
        end
        if (r_state == S_DIV && div_done) begin
            r_res_idx <= r_fill[IW-1:0];
        end
        if (sweep_adv && rq_more) begin
            r_rd_idx <= r_rq_cnt[IW-1:0];
        end
        if (sweep_adv && rd_expire) begin
            r_o_kind <= KIND_EXPIRY;
            r_o_last <= 1'b0;
            r_o_data <= pack_result(exp_slot_x[SLOT_W-1:0], rd_own, ST_OK,
                                    '0, '0, 1'b0, CUR_NONE);
        end else if (r_state == S_SUMMARY && out_free) begin
            r_o_kind <= KIND_SUMMARY;
            r_o_last <= 1'b1;
            r_o_data <= pack_result('0, '0, ST_OK, r_ticks, r_clock, r_hk, r_cur);
        end else if (r_state == S_RESULT && out_free) begin
            r_o_kind <= KIND_CREATE;
            r_o_last <= 1'b1;
            r_o_data <= pack_result(res_slot_x[SLOT_W-1:0], '0, r_status,
                                    '0, '0, 1'b0, CUR_NONE);
        end
    end

    stb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dur_adj),
        .i_divisor  (tick_len),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    stb_mem #(
        .DEPTH (NUM_TIMERS),
        .AW    (IW),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rq_cnt[IW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

endmodule
